FILE: src/jks_pkg.sv
// ----------------------------------------------------------------------------
// jks_pkg
// Shared constants, widths and types for the constant-jerk kinematic step.
// ----------------------------------------------------------------------------
package jks_pkg;

  // Fixed-point format: every value carries FRAC_BITS fractional bits
  localparam int FRAC_BITS = 16;

  // Field widths fixed by the interface
  localparam int VAL_W  = 32;
  localparam int DT_W   = 17;
  localparam int EXT_W  = VAL_W + 1;            // difference of two values
  localparam int JP_W   = 2 * EXT_W;            // jerk product
  localparam int PROD_W = VAL_W + DT_W + 1;     // value times a step factor
  localparam int TERM_W = PROD_W - FRAC_BITS;   // that product after scaling
  localparam int SIXTH_W = FRAC_BITS - 1;       // signed width of one sixth
  localparam int TS_W   = TERM_W + SIXTH_W;
  localparam int SUM_W  = ((TERM_W > EXT_W) ? TERM_W : EXT_W) + 3;

  // Thresholds and scale factors
  localparam logic signed [EXT_W-1:0] FAST_THRESH =
    EXT_W'((2 ** FRAC_BITS + 5) / 10);
  localparam logic signed [EXT_W-1:0] GAP_THRESH =
    EXT_W'(3 * ((2 ** FRAC_BITS) / 2));
  localparam logic signed [SIXTH_W-1:0] SIXTH_Q =
    SIXTH_W'((2 ** FRAC_BITS + 3) / 6);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FAST_ACC_TO_DEC = 3'd0,
    CFG_FAST_DEC_TO_ACC = 3'd1,
    CFG_STEP_TIME       = 3'd2,
    CFG_STEP_TIME_SQ    = 3'd3,
    CFG_STEP_TIME_CUBE  = 3'd4,
    CFG_INV_STEP_TIME   = 3'd5
  } cfg_idx_t;

  // Multiplier operands chosen for the jerk product
  typedef struct packed {
    logic signed [EXT_W-1:0] ma;
    logic signed [EXT_W-1:0] mb;
  } jks_mul_op_t;

endpackage

FILE: src/jks_jerk_sel.sv
// ----------------------------------------------------------------------------
// jks_jerk_sel
// Picks the two operands whose product, once scaled, is the applied jerk.
// ----------------------------------------------------------------------------
module jks_jerk_sel
  import jks_pkg::*;
(
  input  logic                    fast_acc_to_dec_en,
  input  logic                    fast_dec_to_acc_en,
  input  logic [VAL_W-1:0]        inv_step_time,
  input  logic signed [VAL_W-1:0] cur_accel,
  input  logic signed [VAL_W-1:0] target_accel,
  input  logic signed [VAL_W-1:0] jerk_gain,
  output jks_mul_op_t             op
);

  logic signed [EXT_W-1:0] acc_x;
  logic signed [EXT_W-1:0] tgt_x;
  logic signed [EXT_W-1:0] gain_x;
  logic signed [EXT_W-1:0] inv_x;
  logic signed [EXT_W-1:0] goal_x;
  logic signed [EXT_W-1:0] acc_gap;
  logic                    acc_pos;
  logic                    acc_neg;
  logic                    a2d_hit;
  logic                    d2a_hit;
  logic                    release_hit;

  // Widen operands by one bit so differences cannot wrap
  assign acc_x  = {cur_accel[VAL_W-1], cur_accel};
  assign tgt_x  = {target_accel[VAL_W-1], target_accel};
  assign gain_x = {jerk_gain[VAL_W-1], jerk_gain};
  assign inv_x  = {1'b0, inv_step_time};
  assign goal_x = target_accel[VAL_W-1] ? tgt_x : '0;
  assign acc_gap = acc_x - tgt_x;

  // Sign-crossing and brake-release conditions
  assign acc_pos     = acc_x > FAST_THRESH;
  assign acc_neg     = acc_x < -FAST_THRESH;
  assign a2d_hit     = fast_acc_to_dec_en && acc_pos && (tgt_x <= -FAST_THRESH);
  assign d2a_hit     = fast_dec_to_acc_en && acc_neg && (tgt_x > FAST_THRESH);
  assign release_hit = fast_dec_to_acc_en && acc_neg && (acc_gap < -GAP_THRESH);

  // Choose the operand pair; a negative gain forces a zero product
  always_comb begin
    if (jerk_gain[VAL_W-1]) begin
      op.ma = '0;
      op.mb = gain_x;
    end else if (a2d_hit || d2a_hit) begin
      op.ma = -acc_x;
      op.mb = inv_x;
    end else if (release_hit) begin
      op.ma = goal_x - acc_x;
      op.mb = inv_x;
    end else begin
      op.ma = tgt_x - acc_x;
      op.mb = gain_x;
    end
  end

endmodule

FILE: src/jerk_kinematic_step.sv
// ----------------------------------------------------------------------------
// jerk_kinematic_step
// One constant-jerk integration step of position, speed and acceleration.
// ----------------------------------------------------------------------------
// Takes one beat per clock while s_axis_tready is high and returns one result
// beat per input beat, in order, from the last stage. The six register
// stages are: operand select, jerk and first step products, jerk scaling and
// partial sums, jerk step products, the one-sixth product with the speed and
// acceleration sums, and the final position sum with saturation. A stalled
// output fills the stages behind it; s_axis_tready drops only when every
// stage holds a beat. Configuration writes take effect on the next clock and
// are meant to be made while no beat is in flight.
module jerk_kinematic_step
  import jks_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // cfg_data: register value, low bits used per register width
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // s_axis_tdata: cur_pos, cur_speed, cur_accel, target_accel, jerk_gain
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m_axis_tdata: next_pos, next_speed, next_accel, next_jerk,
  //               reverse_clamped, zero padding
  output logic [135:0] m_axis_tdata
);

  localparam logic signed [JP_W-1:0] JERK_MAX =
    {{(JP_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [JP_W-1:0] JERK_MIN =
    {{(JP_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] S_MAX =
    {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] S_MIN =
    {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] U_MAX =
    {{(SUM_W-VAL_W){1'b0}}, {VAL_W{1'b1}}};

  // Configuration registers
  logic             fast_acc_to_dec_en;
  logic             fast_dec_to_acc_en;
  logic [DT_W-1:0]  step_time;
  logic [DT_W-1:0]  step_time_sq;
  logic [DT_W-1:0]  step_time_cube;
  logic [VAL_W-1:0] inv_step_time;

  // Step factors as signed operands
  logic signed [DT_W:0] dt_s;
  logic signed [DT_W:0] dtsq_s;
  logic signed [DT_W:0] dtcu_s;

  // Stage valid bits and advance enables
  logic [6:1] vld;
  logic [6:1] en;

  // Stage 1
  logic [VAL_W-1:0]        pos1;
  logic signed [VAL_W-1:0] spd1;
  logic signed [VAL_W-1:0] acc1;
  jks_mul_op_t             op1;
  jks_mul_op_t             op_sel;
  // Stage 2
  logic [VAL_W-1:0]        pos2;
  logic signed [VAL_W-1:0] spd2;
  logic signed [VAL_W-1:0] acc2;
  logic signed [JP_W-1:0]  jprod2;
  logic signed [PROD_W-1:0] sdt2;
  logic signed [PROD_W-1:0] adsq2;
  logic signed [PROD_W-1:0] adt2;
  // Stage 3
  logic [VAL_W-1:0]        pos3;
  logic signed [VAL_W-1:0] acc3;
  logic signed [VAL_W-1:0] jerk3;
  logic signed [SUM_W-1:0] nsp3;
  logic signed [SUM_W-1:0] nvp3;
  logic signed [JP_W-1:0]  jsh;
  logic signed [PROD_W-1:0] sdt_sh;
  logic signed [PROD_W-1:0] adsq_sh;
  logic signed [PROD_W-1:0] adt_sh;
  logic signed [VAL_W-1:0] jerk_sat;
  // Stage 4
  logic [VAL_W-1:0]        pos4;
  logic signed [VAL_W-1:0] acc4;
  logic signed [VAL_W-1:0] jerk4;
  logic signed [SUM_W-1:0] nsp4;
  logic signed [SUM_W-1:0] nvp4;
  logic signed [PROD_W-1:0] jc4;
  logic signed [PROD_W-1:0] jq4;
  logic signed [PROD_W-1:0] jd4;
  // Stage 5
  logic [VAL_W-1:0]        pos5;
  logic signed [VAL_W-1:0] jerk5;
  logic signed [SUM_W-1:0] nsp5;
  logic signed [SUM_W-1:0] nv5;
  logic signed [SUM_W-1:0] na5;
  logic signed [TS_W-1:0]  ts5;
  logic signed [PROD_W-1:0] jc_sh;
  logic signed [PROD_W-1:0] jq_sh;
  logic signed [PROD_W-1:0] jd_sh;
  logic signed [TERM_W-1:0] cube_term;
  // Stage 6 (output)
  logic signed [TS_W-1:0]  ts_sh;
  logic signed [SUM_W-1:0] ns_full;
  logic signed [SUM_W-1:0] pos_full;
  logic                    rev_hit;
  logic [VAL_W-1:0]        next_pos;
  logic [VAL_W-1:0]        next_speed;
  logic [VAL_W-1:0]        next_accel;
  logic [VAL_W-1:0]        next_jerk;
  logic                    reverse_clamped;
  logic [VAL_W-1:0]        next_pos_next;
  logic [VAL_W-1:0]        next_speed_next;
  logic [VAL_W-1:0]        next_accel_next;
  logic [VAL_W-1:0]        next_jerk_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_acc_to_dec_en <= 1'b0;
      fast_dec_to_acc_en <= 1'b0;
      step_time          <= DT_W'(6554);
      step_time_sq       <= DT_W'(655);
      step_time_cube     <= DT_W'(66);
      inv_step_time      <= VAL_W'(655360);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FAST_ACC_TO_DEC: fast_acc_to_dec_en <= cfg_data[0];
        CFG_FAST_DEC_TO_ACC: fast_dec_to_acc_en <= cfg_data[0];
        CFG_STEP_TIME:       step_time          <= cfg_data[DT_W-1:0];
        CFG_STEP_TIME_SQ:    step_time_sq       <= cfg_data[DT_W-1:0];
        CFG_STEP_TIME_CUBE:  step_time_cube     <= cfg_data[DT_W-1:0];
        CFG_INV_STEP_TIME:   inv_step_time      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dt_s   = {1'b0, step_time};
  assign dtsq_s = {1'b0, step_time_sq};
  assign dtcu_s = {1'b0, step_time_cube};

  // A stage advances when it is empty or the stage after it advances
  assign en[6] = !vld[6] || m_axis_tready;
  assign en[5] = !vld[5] || en[6];
  assign en[4] = !vld[4] || en[5];
  assign en[3] = !vld[3] || en[4];
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign s_axis_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_axis_tvalid;
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
      if (en[5]) vld[5] <= vld[4];
      if (en[6]) vld[6] <= vld[5];
    end
  end

  // Stage 1: select jerk operands
  jks_jerk_sel u_jerk_sel (
    .fast_acc_to_dec_en (fast_acc_to_dec_en),
    .fast_dec_to_acc_en (fast_dec_to_acc_en),
    .inv_step_time      (inv_step_time),
    .cur_accel          (s_axis_tdata[95:64]),
    .target_accel       (s_axis_tdata[127:96]),
    .jerk_gain          (s_axis_tdata[159:128]),
    .op                 (op_sel)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pos1 <= s_axis_tdata[31:0];
      spd1 <= s_axis_tdata[63:32];
      acc1 <= s_axis_tdata[95:64];
      op1  <= op_sel;
    end
  end

  // Stage 2: jerk product and the step products of speed and acceleration
  always_ff @(posedge clk) begin
    if (en[2]) begin
      pos2   <= pos1;
      spd2   <= spd1;
      acc2   <= acc1;
      jprod2 <= op1.ma * op1.mb;
      sdt2   <= spd1 * dt_s;
      adsq2  <= acc1 * dtsq_s;
      adt2   <= acc1 * dt_s;
    end
  end

  // Stage 3: scale and saturate jerk, form partial sums
  assign jsh     = jprod2 >>> FRAC_BITS;
  assign sdt_sh  = sdt2 >>> FRAC_BITS;
  assign adsq_sh = adsq2 >>> (FRAC_BITS + 1);
  assign adt_sh  = adt2 >>> FRAC_BITS;

  always_comb begin
    if (jsh > JERK_MAX) begin
      jerk_sat = JERK_MAX[VAL_W-1:0];
    end else if (jsh < JERK_MIN) begin
      jerk_sat = JERK_MIN[VAL_W-1:0];
    end else begin
      jerk_sat = jsh[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pos3  <= pos2;
      acc3  <= acc2;
      jerk3 <= jerk_sat;
      nsp3  <= $signed({{(SUM_W-VAL_W){1'b0}}, pos2}) + sdt_sh[SUM_W-1:0]
               + adsq_sh[SUM_W-1:0];
      nvp3  <= $signed({{(SUM_W-VAL_W){spd2[VAL_W-1]}}, spd2}) + adt_sh[SUM_W-1:0];
    end
  end

  // Stage 4: jerk step products
  always_ff @(posedge clk) begin
    if (en[4]) begin
      pos4  <= pos3;
      acc4  <= acc3;
      jerk4 <= jerk3;
      nsp4  <= nsp3;
      nvp4  <= nvp3;
      jc4   <= jerk3 * dtcu_s;
      jq4   <= jerk3 * dtsq_s;
      jd4   <= jerk3 * dt_s;
    end
  end

  // Stage 5: one-sixth product, speed and acceleration sums
  assign jc_sh     = jc4 >>> FRAC_BITS;
  assign jq_sh     = jq4 >>> (FRAC_BITS + 1);
  assign jd_sh     = jd4 >>> FRAC_BITS;
  assign cube_term = jc_sh[TERM_W-1:0];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pos5  <= pos4;
      jerk5 <= jerk4;
      nsp5  <= nsp4;
      nv5   <= nvp4 + jq_sh[SUM_W-1:0];
      na5   <= $signed({{(SUM_W-VAL_W){acc4[VAL_W-1]}}, acc4}) + jd_sh[SUM_W-1:0];
      ts5   <= cube_term * SIXTH_Q;
    end
  end

  // Stage 6: position sum, backward check and saturation
  assign ts_sh    = ts5 >>> FRAC_BITS;
  assign ns_full  = nsp5 + ts_sh[SUM_W-1:0];
  assign pos_full = $signed({{(SUM_W-VAL_W){1'b0}}, pos5});
  assign rev_hit  = ns_full < pos_full;

  always_comb begin
    if (rev_hit) begin
      next_pos_next   = pos5;
      next_speed_next = '0;
      next_accel_next = '0;
      next_jerk_next  = '0;
    end else begin
      next_pos_next = (ns_full > U_MAX) ? U_MAX[VAL_W-1:0] : ns_full[VAL_W-1:0];
      if (nv5 > S_MAX) begin
        next_speed_next = S_MAX[VAL_W-1:0];
      end else if (nv5 < S_MIN) begin
        next_speed_next = S_MIN[VAL_W-1:0];
      end else begin
        next_speed_next = nv5[VAL_W-1:0];
      end
      if (na5 > S_MAX) begin
        next_accel_next = S_MAX[VAL_W-1:0];
      end else if (na5 < S_MIN) begin
        next_accel_next = S_MIN[VAL_W-1:0];
      end else begin
        next_accel_next = na5[VAL_W-1:0];
      end
      next_jerk_next = jerk5;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      next_pos        <= next_pos_next;
      next_speed      <= next_speed_next;
      next_accel      <= next_accel_next;
      next_jerk       <= next_jerk_next;
      reverse_clamped <= rev_hit;
    end
  end

  assign m_axis_tvalid = vld[6];
  assign m_axis_tdata  = {7'b0, reverse_clamped, next_jerk, next_accel, next_speed,
                          next_pos};

  // A clamped beat carries zero speed, acceleration and jerk
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && reverse_clamped) |->
      (next_speed == '0 && next_accel == '0 && next_jerk == '0))
    else $error("clamped beat with non-zero motion state");

  // Input side stalls only when the output beat is held back
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // Pipeline comes out of reset empty
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid straight after reset");

endmodule

FILE: verif/jks_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jks_checker
// Watches the register port and both streams of the kinematic step, predicts
// each result from its own copy of the registers and compares field by field.
// ----------------------------------------------------------------------------
// Every accepted input beat is run through a wide-integer model of the jerk
// choice and the constant-jerk integration. The prediction is queued and
// compared in order with the accepted output beats. Counters are handed to
// the testbench top for the end-of-run verdict.
module jks_checker
  import jks_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,
  output int           fail_count,
  output int           pending,
  output int           checked,
  output int           clamped
);

  // Wide enough that no product or sum of the step can wrap
  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] spd;
    logic [31:0] acc;
    logic [31:0] jerk;
    logic        clamped;
  } step_result_t;

  localparam int    FB       = FRAC_BITS;
  localparam wide_t ONE      = 96'sd1 <<< FB;
  localparam wide_t FAST_LIM = (ONE + 5) / 10;
  localparam wide_t GAP_LIM  = 3 * (ONE / 2);
  localparam wide_t SIXTH    = (ONE + 3) / 6;
  localparam wide_t S32_HI   = (96'sd1 <<< 31) - 1;
  localparam wide_t S32_LO   = -(96'sd1 <<< 31);
  localparam wide_t U32_HI   = (96'sd1 <<< 32) - 1;

  // Local copy of the configuration registers
  logic        cfg_a2d;
  logic        cfg_d2a;
  logic [16:0] cfg_dt;
  logic [16:0] cfg_dt2;
  logic [16:0] cfg_dt3;
  logic [31:0] cfg_inv;

  step_result_t predicted_q[$];
  int errs    = 0;
  int n_chk   = 0;
  int n_clamp = 0;

  // Track register writes; they land on the same edge as in the block
  always @(posedge clk) begin
    if (rst) begin
      cfg_a2d <= 1'b0;
      cfg_d2a <= 1'b0;
      cfg_dt  <= 17'd6554;
      cfg_dt2 <= 17'd655;
      cfg_dt3 <= 17'd66;
      cfg_inv <= 32'd655360;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FAST_ACC_TO_DEC: cfg_a2d <= cfg_data[0];
        CFG_FAST_DEC_TO_ACC: cfg_d2a <= cfg_data[0];
        CFG_STEP_TIME:       cfg_dt  <= cfg_data[16:0];
        CFG_STEP_TIME_SQ:    cfg_dt2 <= cfg_data[16:0];
        CFG_STEP_TIME_CUBE:  cfg_dt3 <= cfg_data[16:0];
        CFG_INV_STEP_TIME:   cfg_inv <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic wide_t clamp_wide(input wide_t v, input wide_t lo, input wide_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Choose the jerk, then integrate one step; >>> on signed floors
  function automatic step_result_t integrate_step(input logic [159:0] beat);
    logic signed [31:0] f_spd, f_acc, f_tgt, f_gain;
    wide_t pos, spd, acc, tgt, gain, jerk, goal;
    wide_t dt, dt2, dt3, inv, npos, nspd, nacc;
    step_result_t r;
    f_spd  = beat[63:32];
    f_acc  = beat[95:64];
    f_tgt  = beat[127:96];
    f_gain = beat[159:128];
    pos  = {64'd0, beat[31:0]};
    spd  = f_spd;
    acc  = f_acc;
    tgt  = f_tgt;
    gain = f_gain;
    dt   = {79'd0, cfg_dt};
    dt2  = {79'd0, cfg_dt2};
    dt3  = {79'd0, cfg_dt3};
    inv  = {64'd0, cfg_inv};

    if (gain < 0) begin
      jerk = '0;
    end else if (cfg_a2d && acc > FAST_LIM && tgt <= -FAST_LIM) begin
      // accelerating into a brake request: drop to zero this step
      jerk = (-acc * inv) >>> FB;
    end else if (cfg_d2a && acc < -FAST_LIM && tgt > FAST_LIM) begin
      // braking into an accelerate request: release this step
      jerk = (-acc * inv) >>> FB;
    end else if (cfg_d2a && acc < -FAST_LIM && (acc - tgt) < -GAP_LIM) begin
      // large brake release: jump toward min(0, target)
      goal = (tgt < 0) ? tgt : '0;
      jerk = ((goal - acc) * inv) >>> FB;
    end else begin
      jerk = (gain * (tgt - acc)) >>> FB;
    end
    jerk = clamp_wide(jerk, S32_LO, S32_HI);

    npos = pos + ((spd * dt) >>> FB) + ((acc * dt2) >>> (FB + 1))
         + ((((jerk * dt3) >>> FB) * SIXTH) >>> FB);
    nspd = spd + ((acc * dt) >>> FB) + ((jerk * dt2) >>> (FB + 1));
    nacc = acc + ((jerk * dt) >>> FB);

    // Hold the position and zero the motion when it would go backwards
    if (npos < pos) begin
      r.pos     = beat[31:0];
      r.spd     = '0;
      r.acc     = '0;
      r.jerk    = '0;
      r.clamped = 1'b1;
    end else begin
      npos      = clamp_wide(npos, '0, U32_HI);
      nspd      = clamp_wide(nspd, S32_LO, S32_HI);
      nacc      = clamp_wide(nacc, S32_LO, S32_HI);
      r.pos     = npos[31:0];
      r.spd     = nspd[31:0];
      r.acc     = nacc[31:0];
      r.jerk    = jerk[31:0];
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      errs++;
    end
  endtask

  // Compare each result beat with the oldest prediction, then queue new ones
  always @(posedge clk) begin
    step_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_q.size() == 0) begin
          $error("result beat 0x%034h with no step outstanding", m_axis_tdata);
          errs++;
        end else begin
          want = predicted_q.pop_front();
          check_field("next_pos",        want.pos,  m_axis_tdata[31:0]);
          check_field("next_speed",      want.spd,  m_axis_tdata[63:32]);
          check_field("next_accel",      want.acc,  m_axis_tdata[95:64]);
          check_field("next_jerk",       want.jerk, m_axis_tdata[127:96]);
          check_field("reverse_clamped", {31'd0, want.clamped},
                      {31'd0, m_axis_tdata[128]});
          check_field("padding", 32'd0, {25'd0, m_axis_tdata[135:129]});
          n_chk++;
          if (want.clamped) n_clamp++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predicted_q.push_back(integrate_step(s_axis_tdata));
    end
    fail_count <= errs;
    pending    <= predicted_q.size();
    checked    <= n_chk;
    clamped    <= n_clamp;
  end

endmodule

FILE: verif/tb_jerk_kinematic_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jerk_kinematic_step
// Stimulus and verdict for the constant-jerk kinematic step.
// ----------------------------------------------------------------------------
// Writes a series of register settings while the block is idle, sends a short
// directed set of boundary steps and then random steps shaped to hit every
// jerk branch, backward-motion blocking and saturation. Input gaps and output
// stalls vary per phase. Checking is done by jks_checker.
module tb_jerk_kinematic_step;
  import jks_pkg::*;

  localparam int Q         = 2 ** FRAC_BITS;
  localparam int FAST      = int'(FAST_THRESH);
  localparam int GAP       = int'(GAP_THRESH);
  localparam int N_PHASES  = 8;
  localparam int PHASE_LEN = 137;
  localparam int LIMIT     = 200_000;

  typedef struct {
    logic        a2d;
    logic        d2a;
    logic [16:0] dt;
    logic [16:0] dt2;
    logic [16:0] dt3;
    logic [31:0] inv;
  } step_cfg_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b1;
  logic [135:0] m_axis_tdata;

  int fail_count;
  int pending;
  int checked;
  int clamped;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int n_sent         = 0;
  int n_cfg          = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  jerk_kinematic_step u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  jks_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .clamped       (clamped)
  );

  // Stall the output side at random
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Give up when the run takes far longer than it should
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // tdata: cur_pos, cur_speed, cur_accel, target_accel, jerk_gain
  function automatic logic [159:0] make_step(input logic [31:0] pos, spd, acc, tgt, gain);
    return {gain, tgt, acc, spd, pos};
  endfunction

  function automatic logic [31:0] rand_span(input int unsigned lim);
    return 32'($urandom_range(2 * lim) - lim);
  endfunction

  // Fixed settings first, including the extremes; random ones afterwards
  function automatic step_cfg_t phase_cfg(input int p);
    step_cfg_t c;
    case (p)
      0: c = '{a2d: 1'b1, d2a: 1'b1, dt: 17'd6554, dt2: 17'd655, dt3: 17'd66,
               inv: 32'd655360};
      1: c = '{a2d: 1'b0, d2a: 1'b0, dt: 17'd65536, dt2: 17'd65536, dt3: 17'd65536,
               inv: 32'd65536};
      2: c = '{a2d: 1'b1, d2a: 1'b0, dt: 17'd1, dt2: 17'd0, dt3: 17'd0,
               inv: 32'hFFFF_FFFF};
      3: c = '{a2d: 1'b0, d2a: 1'b1, dt: 17'd13107, dt2: 17'd2621, dt3: 17'd524,
               inv: 32'd327680};
      default: begin
        c.a2d = 1'($urandom_range(1));
        c.d2a = 1'($urandom_range(1));
        c.dt  = 17'($urandom_range(65536, 1));
        c.dt2 = 17'($urandom_range(65536, 0));
        c.dt3 = 17'($urandom_range(65536, 0));
        c.inv = $urandom_range(32'hFFFF_FFFF, 65536);
      end
    endcase
    return c;
  endfunction

  // Write all six registers on consecutive edges
  task automatic load_cfg(input step_cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FAST_ACC_TO_DEC;
    cfg_data  <= {31'd0, c.a2d};
    @(posedge clk);
    cfg_index <= CFG_FAST_DEC_TO_ACC;
    cfg_data  <= {31'd0, c.d2a};
    @(posedge clk);
    cfg_index <= CFG_STEP_TIME;
    cfg_data  <= {15'd0, c.dt};
    @(posedge clk);
    cfg_index <= CFG_STEP_TIME_SQ;
    cfg_data  <= {15'd0, c.dt2};
    @(posedge clk);
    cfg_index <= CFG_STEP_TIME_CUBE;
    cfg_data  <= {15'd0, c.dt3};
    @(posedge clk);
    cfg_index <= CFG_INV_STEP_TIME;
    cfg_data  <= c.inv;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  // Offer one beat, with random idle cycles ahead of it, and hold until taken
  task automatic push_step(input logic [159:0] beat);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    do @(posedge clk); while (!s_axis_tready);
    n_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_steps();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly plausible motion aimed at each jerk branch, some raw noise
  function automatic logic [159:0] random_step();
    logic [31:0] pos, spd, acc, tgt, gain;
    int unsigned kind;
    kind = $urandom_range(99);
    case ($urandom_range(9))
      0, 1:    pos = 32'hFFFF_FFFF - 32'($urandom_range(64 * Q));
      2:       pos = $urandom_range(64 * Q);
      default: pos = $urandom;
    endcase
    spd = rand_span(40 * Q);
    case ($urandom_range(19))
      0, 1:    gain = {1'b1, 31'($urandom)};
      2:       gain = $urandom;
      default: gain = $urandom_range(4 * Q);
    endcase
    if (kind < 15) begin
      pos  = $urandom;
      spd  = $urandom;
      acc  = $urandom;
      tgt  = $urandom;
      gain = $urandom;
    end else if (kind < 30) begin
      acc = $urandom_range(12 * Q, FAST + 1);
      tgt = -32'($urandom_range(12 * Q, FAST));
    end else if (kind < 45) begin
      acc = -32'($urandom_range(12 * Q, FAST + 1));
      tgt = $urandom_range(12 * Q, FAST + 1);
    end else if (kind < 60) begin
      acc = -32'($urandom_range(12 * Q, FAST + 1));
      tgt = acc + 32'(GAP + 1 + $urandom_range(4 * Q));
      if ($signed(tgt) > FAST) tgt = FAST;
    end else if (kind < 70) begin
      // one step either side of the thresholds
      acc = 32'(FAST + $urandom_range(2) - 1);
      if ($urandom_range(1)) acc = -acc;
      if ($urandom_range(1)) begin
        tgt = acc + 32'(GAP + $urandom_range(2) - 1);
      end else begin
        tgt = 32'(FAST + $urandom_range(2) - 1);
        if ($urandom_range(1)) tgt = -tgt;
      end
    end else begin
      acc = rand_span(12 * Q);
      tgt = rand_span(12 * Q);
    end
    return make_step(pos, spd, acc, tgt, gain);
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed boundary steps, both fast modes on
    load_cfg(phase_cfg(0));
    push_step(make_step(32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    push_step(make_step(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF));
    push_step(make_step(32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000));
    push_step(make_step(32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    push_step(make_step(32'h1000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF));
    push_step(make_step(100 * Q, 10 * Q, Q, 3 * Q, 32'hFFFF_FFFF));
    push_step(make_step(100 * Q, 10 * Q, Q, 3 * Q, 32'd0));
    push_step(make_step(100 * Q, 10 * Q, Q, 2 * Q, 2 * Q));
    push_step(make_step(100 * Q, 10 * Q, FAST, -FAST, Q));
    push_step(make_step(100 * Q, 10 * Q, FAST + 1, -FAST, Q));
    push_step(make_step(100 * Q, 10 * Q, FAST + 1, -FAST + 1, Q));
    push_step(make_step(100 * Q, 10 * Q, -(FAST + 1), FAST, Q));
    push_step(make_step(100 * Q, 10 * Q, -(FAST + 1), FAST + 1, Q));
    push_step(make_step(100 * Q, 10 * Q, -2 * Q, -2 * Q + GAP, Q));
    push_step(make_step(100 * Q, 10 * Q, -2 * Q, -2 * Q + GAP + 1, Q));
    push_step(make_step(100 * Q, 10 * Q, -3 * Q, 0, Q));
    push_step(make_step(100 * Q, -10 * Q, 0, 0, 0));
    push_step(make_step(32'd0, 32'hFFFF_FFFF, 0, 0, 0));
    push_step(make_step(32'hFFFF_FFF0, 10 * Q, 0, 0, 0));
    push_step(make_step(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0));
    push_step(make_step(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF));
    drain_steps();

    // Phases of random steps: new settings and a new flow-control mix each time
    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 75; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 75; end
        default: begin send_idle_pct <= 17; recv_stall_pct <= 17; end
      endcase
      load_cfg(phase_cfg(p));
      for (int i = 0; i < PHASE_LEN; i++) push_step(random_step());
      drain_steps();
    end

    // Let any stray result show up before the verdict
    repeat (20) @(posedge clk);
    $display("Sent %0d steps across %0d register settings and four flow-control mixes.",
             n_sent, n_cfg);
    $display("Checked %0d results, %0d of them with backward motion blocked.",
             checked, clamped);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: jerk_kinematic_step.f
src/jks_pkg.sv
src/jks_jerk_sel.sv
src/jerk_kinematic_step.sv
verif/jks_checker.sv
verif/tb_jerk_kinematic_step.sv
